### design/mme_pkg.sv
`timescale 1ns / 1ps
// Shared widths, codes, defaults and helpers for the matrix multiply engine.
package mme_pkg;

   // Field widths of the channels.
   localparam int OP_W      = 2;
   localparam int ROW_W     = 6;
   localparam int COL_W     = 6;
   localparam int VAL_W     = 16;
   localparam int ACC_W     = 40;
   localparam int DIM_W     = 7;
   localparam int CSR_IDX_W = 2;

   // Default sizes handed to the top level parameters.
   localparam int DEF_MAX_ROWS      = 64;
   localparam int DEF_MAX_INNER     = 64;
   localparam int DEF_MAX_COLS      = 64;
   localparam int DEF_ELEMENT_WIDTH = 16;

   // Dimension value that every size register takes at reset, clamped to its bound.
   localparam logic [DIM_W-1:0] DIM_RESET = 7'd64;

   // Operation codes of a request transaction.
   localparam logic [OP_W-1:0] OP_LOAD_LEFT  = 2'd0;
   localparam logic [OP_W-1:0] OP_LOAD_RIGHT = 2'd1;
   localparam logic [OP_W-1:0] OP_COMPUTE    = 2'd2;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_ROWS_USED  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INNER_USED = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COLS_USED  = 2'd2;

   // Control from the sequencer to the multiply-accumulate core.
   typedef struct packed {
      logic             issue;
      logic             clear;
      logic [ROW_W-1:0] row;
      logic [DIM_W-1:0] k;
      logic [COL_W-1:0] col;
   } mme_mac_ctl_type;

   // One element write into either store.
   typedef struct packed {
      logic             wr_left;
      logic             wr_right;
      logic [ROW_W-1:0] row;
      logic [COL_W-1:0] col;
      logic [VAL_W-1:0] value;
   } mme_load_type;

   // A zero dimension means one; anything above the bound means the bound.
   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                  input int bound);
      logic [DIM_W-1:0] r;
      r = v;
      if (v == '0) begin
         r = 7'd1;
      end else if (int'(v) > bound) begin
         r = DIM_W'(bound);
      end
      return r;
   endfunction

endpackage

### design/mme_interfaces.sv
`timescale 1ns / 1ps
// Channel interfaces for requests, responses and configuration writes.
interface mme_req_if;
   import mme_pkg::*;
   logic                    valid;
   logic                    ready;
   logic [OP_W-1:0]         opcode;
   logic [ROW_W-1:0]        row_index;
   logic [COL_W-1:0]        col_index;
   logic signed [VAL_W-1:0] element_value;
   modport source (output valid, opcode, row_index, col_index, element_value,
                   input ready);
   modport sink (input valid, opcode, row_index, col_index, element_value,
                 output ready);
endinterface

interface mme_rsp_if;
   import mme_pkg::*;
   logic                    valid;
   logic                    ready;
   logic [ROW_W-1:0]        out_row;
   logic [COL_W-1:0]        out_col;
   logic signed [ACC_W-1:0] out_value;
   logic                    out_last;
   modport source (output valid, out_row, out_col, out_value, out_last,
                   input ready);
   modport sink (input valid, out_row, out_col, out_value, out_last,
                 output ready);
endinterface

interface mme_csr_if;
   import mme_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [DIM_W-1:0]     data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

### design/mme_mac_core.sv
`timescale 1ns / 1ps
// Element stores and the shared multiply-accumulate unit.
module mme_mac_core #(
   parameter int MAX_ROWS      = mme_pkg::DEF_MAX_ROWS,
   parameter int MAX_INNER     = mme_pkg::DEF_MAX_INNER,
   parameter int MAX_COLS      = mme_pkg::DEF_MAX_COLS,
   parameter int ELEMENT_WIDTH = mme_pkg::DEF_ELEMENT_WIDTH
) (
   input  logic                            clock,
   input  logic                            reset,
   input  mme_pkg::mme_load_type           load,
   input  mme_pkg::mme_mac_ctl_type        ctl,
   output logic signed [mme_pkg::ACC_W-1:0] acc_value,
   output logic                            pipe_busy
);
   import mme_pkg::*;

   localparam int LEFT_DEPTH  = MAX_ROWS * MAX_INNER;
   localparam int RIGHT_DEPTH = MAX_INNER * MAX_COLS;
   localparam int LEFT_AW     = (LEFT_DEPTH > 1) ? $clog2(LEFT_DEPTH) : 1;
   localparam int RIGHT_AW    = (RIGHT_DEPTH > 1) ? $clog2(RIGHT_DEPTH) : 1;
   localparam int PROD_W      = 2 * ELEMENT_WIDTH;

   logic signed [ELEMENT_WIDTH-1:0] left_mem  [LEFT_DEPTH];
   logic signed [ELEMENT_WIDTH-1:0] right_mem [RIGHT_DEPTH];

   logic [LEFT_AW-1:0]              left_wr_addr;
   logic [RIGHT_AW-1:0]             right_wr_addr;
   logic [LEFT_AW-1:0]              left_rd_addr;
   logic [RIGHT_AW-1:0]             right_rd_addr;
   logic signed [ELEMENT_WIDTH-1:0] load_elem;

   logic signed [ELEMENT_WIDTH-1:0] left_q_ff;
   logic signed [ELEMENT_WIDTH-1:0] right_q_ff;
   logic                            rd_vld_ff;
   logic signed [PROD_W-1:0]        prod_ff;
   logic signed [PROD_W-1:0]        prod_in;
   logic                            prod_vld_ff;
   logic signed [ACC_W-1:0]         acc_ff;
   logic signed [ACC_W-1:0]         acc_in;

   // Row-major addressing of both stores.
   assign left_wr_addr  = LEFT_AW'(32'(load.row) * 32'(MAX_INNER) + 32'(load.col));
   assign right_wr_addr = RIGHT_AW'(32'(load.row) * 32'(MAX_COLS) + 32'(load.col));
   assign left_rd_addr  = LEFT_AW'(32'(ctl.row) * 32'(MAX_INNER) + 32'(ctl.k));
   assign right_rd_addr = RIGHT_AW'(32'(ctl.k) * 32'(MAX_COLS) + 32'(ctl.col));

   // The element keeps the low bits of the value, sign-extended.
   assign load_elem = ELEMENT_WIDTH'($signed(load.value));

   // Left store: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (load.wr_left) begin
         left_mem[left_wr_addr] <= load_elem;
      end
      left_q_ff <= left_mem[left_rd_addr];
   end

   // Right store: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (load.wr_right) begin
         right_mem[right_wr_addr] <= load_elem;
      end
      right_q_ff <= right_mem[right_rd_addr];
   end

   // Product register, then accumulation wrapping at the result width.
   assign prod_in = left_q_ff * right_q_ff;

   always_comb begin
      acc_in = acc_ff;
      if (ctl.clear) begin
         acc_in = '0;
      end else if (prod_vld_ff) begin
         acc_in = acc_ff + ACC_W'(prod_ff);
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

   // Valid flags that follow each issued term through the pipeline.
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff   <= 1'b0;
         prod_vld_ff <= 1'b0;
      end else begin
         rd_vld_ff   <= ctl.issue;
         prod_vld_ff <= rd_vld_ff;
      end
   end

   assign acc_value = acc_ff;
   assign pipe_busy = rd_vld_ff | prod_vld_ff;

endmodule

### design/matrix_multiply_engine.sv
`timescale 1ns / 1ps
// Top level of the matrix multiply engine: sequencer, size registers, response register.
//
// Requests arrive on req_ch. A load transaction (opcode load left or load right)
// writes one element into the a or b store; loads outside the sizes in use are
// dropped. A compute transaction names a row of c and yields one response
// transaction per column on rsp_ch, the last one flagged.
// Opcode 3 and a row outside rows_used produce nothing.
// For each column, terms go one a cycle through the single read port of each store
// and one shared multiplier; the sequencer then waits for the read, product and
// accumulator registers to drain and loads the response register. req_ch.ready is
// low while a row is computed, and stays low through any receiver stall. The next
// request is taken while the final response still waits.
// If the receiver stalls, the sequencer holds the finished column until the
// response register is free. csr_ch writes the sizes; it is always ready, and
// writes are to happen only while no compute is in flight.
// Reset clears the sequencer, the response valid and sets all sizes to 64
// (or the parameter bound); the stores keep no reset value.
module matrix_multiply_engine #(
   parameter int MAX_ROWS      = mme_pkg::DEF_MAX_ROWS,
   parameter int MAX_INNER     = mme_pkg::DEF_MAX_INNER,
   parameter int MAX_COLS      = mme_pkg::DEF_MAX_COLS,
   parameter int ELEMENT_WIDTH = mme_pkg::DEF_ELEMENT_WIDTH
) (
   input  logic       clock,
   input  logic       reset,
   mme_req_if.sink    req_ch,
   mme_rsp_if.source  rsp_ch,
   mme_csr_if.sink    csr_ch
);
   import mme_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_RUN   = 4'b0010,
      ST_DRAIN = 4'b0100,
      ST_EMIT  = 4'b1000
   } mme_state_type;

   mme_state_type           state_ff;
   mme_state_type           state_in;
   logic [ROW_W-1:0]        row_ff;
   logic [ROW_W-1:0]        row_in;
   logic [DIM_W-1:0]        k_ff;
   logic [DIM_W-1:0]        k_in;
   logic [COL_W-1:0]        col_ff;
   logic [COL_W-1:0]        col_in;

   logic [DIM_W-1:0]        rows_used_ff;
   logic [DIM_W-1:0]        inner_used_ff;
   logic [DIM_W-1:0]        cols_used_ff;

   logic                    rsp_valid_ff;
   logic                    rsp_valid_in;
   logic [ROW_W-1:0]        rsp_row_ff;
   logic [COL_W-1:0]        rsp_col_ff;
   logic signed [ACC_W-1:0] rsp_value_ff;
   logic                    rsp_last_ff;

   logic                    req_fire;
   logic                    start_row;
   logic                    last_k;
   logic                    last_col;
   logic                    emit;
   logic                    pipe_busy;
   logic signed [ACC_W-1:0] acc_value;
   mme_mac_ctl_type         ctl;
   mme_load_type            load;

   assign req_fire  = req_ch.valid & req_ch.ready;
   assign req_ch.ready = (state_ff == ST_IDLE);
   assign csr_ch.ready = 1'b1;

   assign start_row = req_fire && (req_ch.opcode == OP_COMPUTE) &&
                      ({1'b0, req_ch.row_index} < rows_used_ff);
   assign last_k    = (k_ff == inner_used_ff - 7'd1);
   assign last_col  = ({1'b0, col_ff} == cols_used_ff - 7'd1);

   // Element writes, kept only inside the sizes in use.
   always_comb begin
      load.wr_left  = req_fire && (req_ch.opcode == OP_LOAD_LEFT) &&
                      ({1'b0, req_ch.row_index} < rows_used_ff) &&
                      ({1'b0, req_ch.col_index} < inner_used_ff);
      load.wr_right = req_fire && (req_ch.opcode == OP_LOAD_RIGHT) &&
                      ({1'b0, req_ch.row_index} < inner_used_ff) &&
                      ({1'b0, req_ch.col_index} < cols_used_ff);
      load.row      = req_ch.row_index;
      load.col      = req_ch.col_index;
      load.value    = req_ch.element_value;
   end

   // Sequencer: one term per cycle, then drain, then hand over the column.
   always_comb begin
      state_in  = state_ff;
      row_in    = row_ff;
      k_in      = k_ff;
      col_in    = col_ff;
      ctl.issue = 1'b0;
      ctl.clear = 1'b0;
      emit      = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (start_row) begin
               row_in    = req_ch.row_index;
               k_in      = '0;
               col_in    = '0;
               ctl.clear = 1'b1;
               state_in  = ST_RUN;
            end
         end
         ST_RUN: begin
            ctl.issue = 1'b1;
            if (last_k) begin
               state_in = ST_DRAIN;
            end else begin
               k_in = k_ff + 7'd1;
            end
         end
         ST_DRAIN: begin
            if (!pipe_busy) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               emit = 1'b1;
               if (last_col) begin
                  state_in = ST_IDLE;
               end else begin
                  col_in    = col_ff + 6'd1;
                  k_in      = '0;
                  ctl.clear = 1'b1;
                  state_in  = ST_RUN;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      ctl.row = row_ff;
      ctl.k   = k_ff;
      ctl.col = col_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      row_ff <= row_in;
      k_ff   <= k_in;
      col_ff <= col_in;
   end

   // Size registers, clamped on write.
   always_ff @(posedge clock) begin
      if (reset) begin
         rows_used_ff  <= clamp_dim(DIM_RESET, MAX_ROWS);
         inner_used_ff <= clamp_dim(DIM_RESET, MAX_INNER);
         cols_used_ff  <= clamp_dim(DIM_RESET, MAX_COLS);
      end else if (csr_ch.valid && csr_ch.ready) begin
         case (csr_ch.index)
            CSR_ROWS_USED:  rows_used_ff  <= clamp_dim(csr_ch.data, MAX_ROWS);
            CSR_INNER_USED: inner_used_ff <= clamp_dim(csr_ch.data, MAX_INNER);
            CSR_COLS_USED:  cols_used_ff  <= clamp_dim(csr_ch.data, MAX_COLS);
            default: begin
            end
         endcase
      end
   end

   // Response register decouples the sequencer from the receiver.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (emit) begin
         rsp_row_ff   <= row_ff;
         rsp_col_ff   <= col_ff;
         rsp_value_ff <= acc_value;
         rsp_last_ff  <= last_col;
      end
   end

   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.out_row   = rsp_row_ff;
   assign rsp_ch.out_col   = rsp_col_ff;
   assign rsp_ch.out_value = rsp_value_ff;
   assign rsp_ch.out_last  = rsp_last_ff;

   mme_mac_core #(
      .MAX_ROWS      (MAX_ROWS),
      .MAX_INNER     (MAX_INNER),
      .MAX_COLS      (MAX_COLS),
      .ELEMENT_WIDTH (ELEMENT_WIDTH)
   ) u_mac_core (
      .clock     (clock),
      .reset     (reset),
      .load      (load),
      .ctl       (ctl),
      .acc_value (acc_value),
      .pipe_busy (pipe_busy)
   );

   // A new response only ever comes out of the hand-over state.
   a_rsp_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_EMIT))
      else $error("response raised outside hand-over");

   // The accumulator is complete when a column is handed over.
   a_emit_pipe_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> !pipe_busy)
      else $error("column handed over with terms in flight");

   // Term index stays inside the inner size while terms are issued.
   a_k_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN) |-> (k_ff < inner_used_ff))
      else $error("term index out of range");

   // Row and column under work stay inside the sizes in use.
   a_pos_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |->
         (({1'b0, col_ff} < cols_used_ff) && ({1'b0, row_ff} < rows_used_ff)))
      else $error("row or column out of range");

   // A valid compute transaction starts the term loop at once.
   a_start_run: assert property (@(posedge clock) disable iff (reset)
      start_row |=> (state_ff == ST_RUN) && (k_ff == '0) && (col_ff == '0))
      else $error("compute did not start");

endmodule

### verif/tb_matrix_multiply_engine.sv
`timescale 1ns / 1ps
// Self-checking testbench for the matrix multiply engine: directed table, then random phases.
module tb_matrix_multiply_engine;
   import mme_pkg::*;

   // Run lengths, in clock cycles.
   localparam int CYCLE_LIMIT   = 1000000;
   localparam int SETTLE_CYCLES = 80;
   localparam int LONG_HOLD     = 400;
   localparam int MAX_PRINTED   = 50;

   // Opcode that the block leaves unused.
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

   // One request transaction.
   typedef struct {
      logic [OP_W-1:0]         opcode;
      logic [ROW_W-1:0]        row;
      logic [COL_W-1:0]        col;
      logic signed [VAL_W-1:0] value;
   } mme_req_type;

   // One element of the product matrix.
   typedef struct {
      logic [ROW_W-1:0]        row;
      logic [COL_W-1:0]        col;
      logic signed [ACC_W-1:0] value;
      logic                    last;
   } c_elem_type;

   // A directed row; a count of -1 leaves the results to the predictor.
   typedef struct {
      mme_req_type      req;
      int               n_fixed;
      logic [ACC_W-1:0] fixed0;
      logic [ACC_W-1:0] fixed1;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset;

   mme_req_if req_ch ();
   mme_rsp_if rsp_ch ();
   mme_csr_if csr_ch ();

   matrix_multiply_engine u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   // Predictor state: both stores, which entries hold data, and the sizes in use.
   logic signed [VAL_W-1:0] left_store    [DEF_MAX_ROWS*DEF_MAX_INNER];
   logic signed [VAL_W-1:0] right_store   [DEF_MAX_INNER*DEF_MAX_COLS];
   bit                      left_written  [DEF_MAX_ROWS*DEF_MAX_INNER];
   bit                      right_written [DEF_MAX_INNER*DEF_MAX_COLS];
   logic [DIM_W-1:0]        rows_sz  = DIM_RESET;
   logic [DIM_W-1:0]        inner_sz = DIM_RESET;
   logic [DIM_W-1:0]        cols_sz  = DIM_RESET;

   c_elem_type   pending_c [$];
   stim_row_type stim_table [$];
   int           mismatch_count = 0;
   int           rsp_count      = 0;
   int           cycle_count    = 0;
   bit           rsp_took       = 1'b0;
   bit           sender_fast    = 1'b0;
   c_elem_type   want;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Abort a hung run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   task automatic report_mismatch(input string field, input int row, input int col,
                                  input logic [ACC_W-1:0] got,
                                  input logic [ACC_W-1:0] wanted);
      if (mismatch_count < MAX_PRINTED) begin
         $display("MISMATCH %s at c[%0d][%0d]: got %0h, expected %0h", field, row, col,
                  got, wanted);
      end
      mismatch_count++;
   endtask

   // Size registers: zero reads as one, anything past the bound reads as the bound.
   function automatic logic [DIM_W-1:0] fit_size(input logic [DIM_W-1:0] v, input int bound);
      if (v == '0) begin
         return DIM_W'(1);
      end
      return (int'(v) > bound) ? DIM_W'(bound) : v;
   endfunction

   // Apply one request to the predicted stores and list the c elements it yields.
   task automatic step_matrices(input mme_req_type it, output c_elem_type row_out [$]);
      c_elem_type              e;
      logic signed [ACC_W-1:0] acc;
      row_out = {};
      case (it.opcode)
         OP_LOAD_LEFT: begin
            if (it.row < rows_sz && it.col < inner_sz) begin
               left_store[int'(it.row) * DEF_MAX_INNER + int'(it.col)]   = it.value;
               left_written[int'(it.row) * DEF_MAX_INNER + int'(it.col)] = 1'b1;
            end
         end
         OP_LOAD_RIGHT: begin
            if (it.row < inner_sz && it.col < cols_sz) begin
               right_store[int'(it.row) * DEF_MAX_COLS + int'(it.col)]   = it.value;
               right_written[int'(it.row) * DEF_MAX_COLS + int'(it.col)] = 1'b1;
            end
         end
         OP_COMPUTE: begin
            if (it.row < rows_sz) begin
               for (int j = 0; j < int'(cols_sz); j++) begin
                  acc = '0;
                  for (int k = 0; k < int'(inner_sz); k++) begin
                     acc = acc + left_store[int'(it.row) * DEF_MAX_INNER + k] *
                                 right_store[k * DEF_MAX_COLS + j];
                  end
                  e.row   = it.row;
                  e.col   = COL_W'(j);
                  e.value = acc;
                  e.last  = (j == int'(cols_sz) - 1);
                  row_out.push_back(e);
               end
            end
         end
         default: begin
         end
      endcase
   endtask

   // A compute of this row reads only entries that have been loaded.
   function automatic bit row_ready(input logic [ROW_W-1:0] row);
      bit ok;
      ok = 1'b1;
      for (int k = 0; k < int'(inner_sz); k++) begin
         if (!left_written[int'(row) * DEF_MAX_INNER + k]) ok = 1'b0;
         for (int j = 0; j < int'(cols_sz); j++) begin
            if (!right_written[k * DEF_MAX_COLS + j]) ok = 1'b0;
         end
      end
      return ok;
   endfunction

   // Load of the first entry that a compute of this row still lacks, a before b.
   function automatic mme_req_type missing_load(input logic [ROW_W-1:0] row);
      mme_req_type it;
      it.opcode = OP_UNUSED;
      it.row    = row;
      it.col    = '0;
      it.value  = VAL_W'($urandom_range(0, 65535));
      for (int k = int'(inner_sz) - 1; k >= 0; k--) begin
         for (int j = int'(cols_sz) - 1; j >= 0; j--) begin
            if (!right_written[k * DEF_MAX_COLS + j]) begin
               it.opcode = OP_LOAD_RIGHT;
               it.row    = ROW_W'(k);
               it.col    = COL_W'(j);
            end
         end
      end
      for (int k = int'(inner_sz) - 1; k >= 0; k--) begin
         if (!left_written[int'(row) * DEF_MAX_INNER + k]) begin
            it.opcode = OP_LOAD_LEFT;
            it.row    = row;
            it.col    = COL_W'(k);
         end
      end
      return it;
   endfunction

   // Offer one request after a random gap; predict its results once it is taken.
   task automatic send_request(input mme_req_type it, input int n_fixed,
                               input logic [ACC_W-1:0] v0, input logic [ACC_W-1:0] v1);
      c_elem_type row_out [$];
      c_elem_type e;
      int         gap;
      gap = sender_fast ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid         <= 1'b1;
      req_ch.opcode        <= it.opcode;
      req_ch.row_index     <= it.row;
      req_ch.col_index     <= it.col;
      req_ch.element_value <= it.value;
      do @(posedge clock); while (!req_ch.ready);
      step_matrices(it, row_out);
      // Hand-typed results replace the predicted ones for the plain directed rows.
      if (n_fixed >= 0) begin
         row_out = {};
         for (int j = 0; j < n_fixed; j++) begin
            e.row   = it.row;
            e.col   = COL_W'(j);
            e.value = (j == 0) ? v0 : v1;
            e.last  = (j == n_fixed - 1);
            row_out.push_back(e);
         end
      end
      foreach (row_out[n]) pending_c.push_back(row_out[n]);
      @(negedge clock);
   endtask

   // Stop sending until every predicted element has arrived and the block is idle.
   task automatic drain_results(input int settle);
      req_ch.valid <= 1'b0;
      do @(negedge clock); while (pending_c.size() != 0);
      repeat (settle) @(negedge clock);
      while (!req_ch.ready) @(negedge clock);
   endtask

   // Write all three size registers, one transaction each.
   task automatic write_sizes(input logic [DIM_W-1:0] r, input logic [DIM_W-1:0] i,
                              input logic [DIM_W-1:0] c);
      logic [DIM_W-1:0]     vals [3];
      logic [CSR_IDX_W-1:0] idx  [3];
      vals = '{r, i, c};
      idx  = '{CSR_ROWS_USED, CSR_INNER_USED, CSR_COLS_USED};
      for (int n = 0; n < 3; n++) begin
         csr_ch.valid <= 1'b1;
         csr_ch.index <= idx[n];
         csr_ch.data  <= vals[n];
         do @(posedge clock); while (!csr_ch.ready);
         case (idx[n])
            CSR_ROWS_USED:  rows_sz  = fit_size(vals[n], DEF_MAX_ROWS);
            CSR_INNER_USED: inner_sz = fit_size(vals[n], DEF_MAX_INNER);
            CSR_COLS_USED:  cols_sz  = fit_size(vals[n], DEF_MAX_COLS);
            default: begin
            end
         endcase
         @(negedge clock);
      end
      csr_ch.valid <= 1'b0;
   endtask

   task automatic add_stim(input logic [OP_W-1:0] op, input int row, input int col,
                           input int val, input int n_fixed,
                           input logic [ACC_W-1:0] v0, input logic [ACC_W-1:0] v1);
      stim_row_type s;
      s.req.opcode = op;
      s.req.row    = ROW_W'(row);
      s.req.col    = COL_W'(col);
      s.req.value  = VAL_W'(val);
      s.n_fixed    = n_fixed;
      s.fixed0     = v0;
      s.fixed1     = v1;
      stim_table.push_back(s);
   endtask

   // Size draw: mostly small, sometimes zero or past the bound.
   function automatic logic [DIM_W-1:0] pick_dim();
      int p;
      p = $urandom_range(0, 9);
      if (p == 0) begin
         return '0;
      end
      if (p == 1) begin
         return DIM_W'($urandom_range(65, 127));
      end
      return DIM_W'($urandom_range(1, 3));
   endfunction

   // Mostly in-range loads and computes with random content, the rest noise.
   // A compute lacking loaded operands becomes a missing load; in noise, the unused opcode.
   function automatic mme_req_type random_request();
      mme_req_type it;
      int          pick;
      pick     = $urandom_range(0, 99);
      it.row   = ROW_W'($urandom_range(0, 63));
      it.col   = COL_W'($urandom_range(0, 63));
      it.value = VAL_W'($urandom_range(0, 65535));
      if (pick < 23) begin
         it.opcode = OP_LOAD_LEFT;
         it.row    = ROW_W'($urandom_range(0, int'(rows_sz) - 1));
         it.col    = COL_W'($urandom_range(0, int'(inner_sz) - 1));
      end else if (pick < 45) begin
         it.opcode = OP_LOAD_RIGHT;
         it.row    = ROW_W'($urandom_range(0, int'(inner_sz) - 1));
         it.col    = COL_W'($urandom_range(0, int'(cols_sz) - 1));
      end else if (pick < 80) begin
         it.opcode = OP_COMPUTE;
         it.row    = ROW_W'($urandom_range(0, int'(rows_sz) - 1));
         if (!row_ready(it.row)) begin
            it = missing_load(it.row);
         end
      end else begin
         it.opcode = OP_W'($urandom_range(0, 3));
         if (it.opcode == OP_COMPUTE && it.row < rows_sz && !row_ready(it.row)) begin
            it.opcode = OP_UNUSED;
         end
      end
      return it;
   endfunction

   // One random phase; with fill set it first loads every missing b entry in use.
   task automatic run_phase(input logic [DIM_W-1:0] r, input logic [DIM_W-1:0] i,
                            input logic [DIM_W-1:0] c, input bit fill, input int n_items);
      mme_req_type it;
      drain_results(SETTLE_CYCLES);
      write_sizes(r, i, c);
      sender_fast = ($urandom_range(0, 2) == 0);
      if (fill) begin
         for (int k = 0; k < int'(inner_sz); k++) begin
            for (int j = 0; j < int'(cols_sz); j++) begin
               if (!right_written[k * DEF_MAX_COLS + j]) begin
                  it.opcode = OP_LOAD_RIGHT;
                  it.row    = ROW_W'(k);
                  it.col    = COL_W'(j);
                  it.value  = VAL_W'($urandom_range(0, 65535));
                  send_request(it, -1, '0, '0);
               end
            end
         end
      end
      for (int n = 0; n < n_items; n++) begin
         send_request(random_request(), -1, '0, '0);
         if ($urandom_range(0, 24) == 0) begin
            drain_results(0);
         end
      end
   endtask

   // Compare every response transaction with the oldest predicted element.
   always @(posedge clock) begin
      rsp_took = 1'b0;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         rsp_took = 1'b1;
         rsp_count++;
         if (pending_c.size() == 0) begin
            report_mismatch("unexpected result", int'(rsp_ch.out_row), int'(rsp_ch.out_col),
                            rsp_ch.out_value, '0);
         end else begin
            want = pending_c.pop_front();
            if (rsp_ch.out_row !== want.row)
               report_mismatch("out_row", int'(want.row), int'(want.col),
                               ACC_W'(rsp_ch.out_row), ACC_W'(want.row));
            if (rsp_ch.out_col !== want.col)
               report_mismatch("out_col", int'(want.row), int'(want.col),
                               ACC_W'(rsp_ch.out_col), ACC_W'(want.col));
            if (rsp_ch.out_value !== want.value)
               report_mismatch("out_value", int'(want.row), int'(want.col),
                               rsp_ch.out_value, want.value);
            if (rsp_ch.out_last !== want.last)
               report_mismatch("out_last", int'(want.row), int'(want.col),
                               ACC_W'(rsp_ch.out_last), ACC_W'(want.last));
         end
      end
   end

   // Receiver: random stalls after each transaction, calm stretches and two long holds.
   initial begin
      int stall_left;
      stall_left   = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_took) begin
            if (rsp_count == 20 || rsp_count == 300) begin
               stall_left = LONG_HOLD;
            end else if ((rsp_count / 48) % 3 == 2) begin
               stall_left = 0;
            end else begin
               stall_left = $urandom_range(0, 7);
            end
         end
         if (stall_left > 0) begin
            rsp_ch.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // Stimulus: directed table under tiny sizes, then random phases.
   initial begin
      reset                <= 1'b1;
      req_ch.valid         <= 1'b0;
      req_ch.opcode        <= OP_LOAD_LEFT;
      req_ch.row_index     <= '0;
      req_ch.col_index     <= '0;
      req_ch.element_value <= '0;
      csr_ch.valid         <= 1'b0;
      csr_ch.index         <= CSR_ROWS_USED;
      csr_ch.data          <= '0;

      // Two rows, one inner term, two columns; each row of c checks both sign extremes.
      add_stim(OP_LOAD_LEFT,  0, 0,  32767, -1, '0, '0);
      add_stim(OP_LOAD_RIGHT, 0, 0,  32767, -1, '0, '0);
      add_stim(OP_LOAD_RIGHT, 0, 1, -32768, -1, '0, '0);
      add_stim(OP_COMPUTE,    0, 63,    -1,  2, 40'h00_3FFF_0001, 40'hFF_C000_8000);
      add_stim(OP_LOAD_LEFT,  1, 0, -32768, -1, '0, '0);
      add_stim(OP_COMPUTE,    1, 0,      0,  2, 40'hFF_C000_8000, 40'h00_4000_0000);
      // Loads outside the sizes in use must leave both stores alone.
      add_stim(OP_LOAD_LEFT,  63, 0,     1,  0, '0, '0);
      add_stim(OP_LOAD_LEFT,  0, 63,     1,  0, '0, '0);
      add_stim(OP_LOAD_RIGHT, 63, 0,     1,  0, '0, '0);
      add_stim(OP_LOAD_RIGHT, 0, 63,     1,  0, '0, '0);
      add_stim(OP_COMPUTE,    0, 21, 12345,  2, 40'h00_3FFF_0001, 40'hFF_C000_8000);
      add_stim(OP_COMPUTE,    1, 42, -4321,  2, 40'hFF_C000_8000, 40'h00_4000_0000);
      // Rows past rows_used and the unused opcode produce nothing.
      add_stim(OP_COMPUTE,    2, 0,      0,  0, '0, '0);
      add_stim(OP_COMPUTE,    63, 63,   -1,  0, '0, '0);
      add_stim(OP_UNUSED,     0, 0,      0,  0, '0, '0);
      add_stim(OP_UNUSED,     63, 63,   -1,  0, '0, '0);
      add_stim(OP_LOAD_LEFT,  1, 0,  16'sh0180, -1, '0, '0);
      add_stim(OP_LOAD_RIGHT, 0, 1,  16'sh0040, -1, '0, '0);
      add_stim(OP_COMPUTE,    1, 7,    100, -1, '0, '0);
      add_stim(OP_LOAD_LEFT,  0, 0,      0, -1, '0, '0);
      add_stim(OP_COMPUTE,    0, 0,      0,  2, '0, '0);

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // A zero write to inner_used must read back as one.
      write_sizes(DIM_W'(2), DIM_W'(0), DIM_W'(2));
      foreach (stim_table[n]) begin
         send_request(stim_table[n].req, stim_table[n].n_fixed, stim_table[n].fixed0,
                      stim_table[n].fixed1);
      end

      // Writes past the bound give full-width rows of c over a single inner term.
      run_phase(DIM_W'(127), DIM_W'(1), DIM_W'(127), 1'b1, 20);
      run_phase(DIM_W'(1), DIM_W'(1), DIM_W'(1), 1'b0, 10);
      run_phase(DIM_W'(0), DIM_W'(2), DIM_W'(1), 1'b0, 10);
      repeat (4) run_phase(pick_dim(), pick_dim(), pick_dim(), 1'b0, 8);

      drain_results(SETTLE_CYCLES);
      if (mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
